### rtl/core/assert_macros.svh
// Assertion macros for the RTL files of the vm step core.
// Depends on a clk and an active-low rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MVS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MVS_ASSERT(lbl, prop, msg)
`define MVS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/mvs_pkg.sv
// Types and constants of the vm step core.
// No dependencies.
package mvs_pkg;

  localparam int WORD_W    = 32;
  localparam int IND_BITS  = 3;
  localparam int OPC_W     = WORD_W - IND_BITS;
  localparam int DIV_CNT_W = 5;
  localparam int IN_W      = 48;
  localparam int OUT_W     = 40;

  // host actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_EXEC  = 2'd2;

  // opcodes (op word bits 31..3)
  localparam logic [OPC_W-1:0] OP_COPY = OPC_W'(0);
  localparam logic [OPC_W-1:0] OP_ADD  = OPC_W'(1);
  localparam logic [OPC_W-1:0] OP_SUB  = OPC_W'(2);
  localparam logic [OPC_W-1:0] OP_MUL  = OPC_W'(3);
  localparam logic [OPC_W-1:0] OP_DIV  = OPC_W'(4);
  localparam logic [OPC_W-1:0] OP_MOD  = OPC_W'(5);
  localparam logic [OPC_W-1:0] OP_AND  = OPC_W'(6);
  localparam logic [OPC_W-1:0] OP_OR   = OPC_W'(7);
  localparam logic [OPC_W-1:0] OP_XOR  = OPC_W'(8);
  localparam logic [OPC_W-1:0] OP_NOT  = OPC_W'(9);
  localparam logic [OPC_W-1:0] OP_LNOT = OPC_W'(10);
  localparam logic [OPC_W-1:0] OP_SHL  = OPC_W'(11);
  localparam logic [OPC_W-1:0] OP_SHR  = OPC_W'(12);
  localparam logic [OPC_W-1:0] OP_SAR  = OPC_W'(13);
  localparam logic [OPC_W-1:0] OP_GT   = OPC_W'(14);
  localparam logic [OPC_W-1:0] OP_EQ   = OPC_W'(15);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ADDR, ST_DATA, ST_ALU, ST_DIV, ST_RESP
  } mvs_state_t;

  // memory access sequence of one beat
  typedef enum logic [4:0] {
    SP_HWR, SP_HRD, SP_PC0, SP_OP, SP_A, SP_B, SP_C, SP_IA, SP_IB, SP_IC,
    SP_X, SP_Y, SP_CR, SP_CW, SP_RW, SP_PC1, SP_PC2
  } mvs_step_t;

endpackage

### rtl/core/memory_to_memory_vm_step_core.sv
// Top level of the vm step core: sequencer around one word memory.
// Depends on mvs_pkg, mvs_ram, mvs_div, mvs_alu and assert_macros.svh.
//
//  channel | dir | fields (lsb first)
//  in_*    | in  | action[1:0], address[15:2], write_data[47:16]
//  out_*   | out | read_data[31:0], halted[32], fault[33], zero pad
//
// Each memory access is an address state (ST_ADDR) plus, for reads, a data state (ST_DATA).
// Executes grow with each indirect operand and each copied word; div and mod also
// wait for the divider. A halted execute reads only the program counter word.
// A MEM_WORDS that is not a power of two lengthens each access by the address wrap.
// After reset a clearing pass zeroes every memory word.
// A result waiting in the output register holds the next beat, and the input.
module memory_to_memory_vm_step_core #(
  parameter int MEM_WORDS = 16384
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [mvs_pkg::IN_W-1:0]  in_tdata,  // action, address, write_data
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [mvs_pkg::OUT_W-1:0] out_tdata  // read_data, halted, fault, pad
);
  import mvs_pkg::*;

  localparam int  AW     = $clog2(MEM_WORDS);
  localparam bit  IS_POW2 = ((1 << AW) == MEM_WORDS);
  localparam logic [WORD_W-1:0] RECIP = WORD_W'((64'd1 << WORD_W) / MEM_WORDS);

  mvs_state_t state_r, state_nxt;
  mvs_step_t  step_r, step_nxt;

  logic [1:0]        act_r;
  logic [13:0]       haddr_r;
  logic [WORD_W-1:0] hdata_r;
  logic [WORD_W-1:0] pc_r, op_r, a_r, b_r, c_r, x_r, y_r, res_r, tmp_r, rdout_r;
  logic [AW:0]       n_r, i_r;
  logic [AW-1:0]     clr_r;
  logic              hlt_r, flt_r, wait_r;
  logic              out_tvalid_r;
  logic [OUT_W-1:0]  out_tdata_r;
  logic [1:0]        wcnt_r;
  logic [WORD_W-1:0] wq_r;
  logic [AW:0]       wrem_r;

  logic [OPC_W-1:0]  opc;
  logic [WORD_W-1:0] raw, wdat, rd, alu_r, div_q, div_r, div_a, div_b;
  logic              ram_en, ram_we, div_start, div_sgn, div_done, wrap_vld;
  logic              is_wr_step, cw_last, out_free;
  logic [AW-1:0]     ram_addr, wrap_addr;
  logic [AW:0]       n_init;
  logic [2*WORD_W-1:0] wprod;
  logic [WORD_W-1:0] wsub;

  assign opc      = op_r[WORD_W-1:IND_BITS];
  assign out_free = !out_tvalid_r || out_tready;
  assign cw_last  = (i_r + 1'b1) == n_r;
  assign n_init   = (rd > WORD_W'(MEM_WORDS)) ? (AW+1)'(MEM_WORDS) : rd[AW:0];

  // raw address and write data of the current step
  always_comb begin
    raw        = '0;
    wdat       = '0;
    is_wr_step = 1'b0;
    case (step_r)
      SP_HWR: begin raw = WORD_W'(haddr_r); wdat = hdata_r; is_wr_step = 1'b1; end
      SP_HRD: raw = WORD_W'(haddr_r);
      SP_OP:  raw = pc_r;
      SP_A:   raw = pc_r + 32'd1;
      SP_B:   raw = pc_r + 32'd2;
      SP_C:   raw = pc_r + 32'd3;
      SP_IA, SP_X: raw = a_r;
      SP_IB, SP_Y: raw = b_r;
      SP_IC:  raw = c_r;
      SP_CR:  raw = a_r + WORD_W'(i_r);
      SP_CW:  begin raw = c_r + WORD_W'(i_r); wdat = tmp_r; is_wr_step = 1'b1; end
      SP_RW:  begin raw = c_r; wdat = res_r; is_wr_step = 1'b1; end
      SP_PC2: begin wdat = tmp_r + 32'd1; is_wr_step = 1'b1; end
      default: raw = '0;
    endcase
  end

  // address wrap: mask, or reciprocal quotient estimate plus one correction
  assign wprod     = (2*WORD_W)'(raw) * (2*WORD_W)'(RECIP);
  assign wsub      = raw - wq_r * WORD_W'(MEM_WORDS);
  assign wrap_addr = IS_POW2 ? raw[AW-1:0] :
                     (wrem_r >= (AW+1)'(MEM_WORDS)) ? AW'(wrem_r - (AW+1)'(MEM_WORDS)) :
                     wrem_r[AW-1:0];
  assign wrap_vld  = (state_r == ST_ADDR) && (IS_POW2 || wcnt_r == 2'd2);

  // next state and step
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_CLEAR: if (clr_r == AW'(MEM_WORDS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_ADDR;
          case (in_tdata[1:0])
            ACT_WRITE: step_nxt = SP_HWR;
            ACT_READ:  step_nxt = SP_HRD;
            ACT_EXEC:  step_nxt = SP_PC0;
            default:   state_nxt = ST_RESP;
          endcase
        end
      end
      ST_ADDR: begin
        if (wrap_vld) begin
          state_nxt = ST_DATA;
          case (step_r)
            SP_HWR, SP_PC2: state_nxt = ST_RESP;
            SP_RW: begin state_nxt = ST_ADDR; step_nxt = SP_PC1; end
            SP_CW: begin
              state_nxt = ST_ADDR;
              step_nxt  = cw_last ? SP_PC1 : SP_CR;
            end
            default: state_nxt = ST_DATA;
          endcase
        end
      end
      ST_DATA: begin
        state_nxt = ST_ADDR;
        case (step_r)
          SP_HRD: state_nxt = ST_RESP;
          SP_PC0: if (rd == '0) state_nxt = ST_RESP; else step_nxt = SP_OP;
          SP_OP:  step_nxt = SP_A;
          SP_A:   step_nxt = SP_B;
          SP_B:   step_nxt = SP_C;
          SP_C:   step_nxt = op_r[0] ? SP_IA : op_r[1] ? SP_IB : op_r[2] ? SP_IC : SP_X;
          SP_IA:  step_nxt = op_r[1] ? SP_IB : op_r[2] ? SP_IC : SP_X;
          SP_IB:  step_nxt = op_r[2] ? SP_IC : SP_X;
          SP_IC:  step_nxt = SP_X;
          SP_X:   step_nxt = SP_Y;
          SP_Y: begin
            if (opc == OP_COPY) begin
              step_nxt = ($signed(rd) <= 0) ? SP_PC1 : SP_CR;
            end else if (opc == OP_DIV || opc == OP_MOD) begin
              if (rd == '0) step_nxt = SP_RW;
              else state_nxt = ST_DIV;
            end else if (opc > OP_EQ) begin
              step_nxt = SP_PC1;
            end else begin
              state_nxt = ST_ALU;
            end
          end
          SP_CR:  step_nxt = SP_CW;
          SP_PC1: step_nxt = SP_PC2;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_ALU: begin state_nxt = ST_ADDR; step_nxt = SP_RW; end
      ST_DIV: if (div_done) begin state_nxt = ST_ADDR; step_nxt = SP_RW; end
      ST_RESP: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = wrap_addr;
    div_start = 1'b0;
    div_sgn   = 1'b0;
    div_a     = x_r;
    div_b     = y_r;
    case (state_r)
      ST_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_r;
      end
      ST_ADDR: begin
        ram_en    = wrap_vld;
        ram_we    = wrap_vld && is_wr_step;
      end
      ST_DIV: begin
        div_start = !wait_r;
        div_sgn   = 1'b1;
      end
      default: ram_en = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      step_r       <= SP_HWR;
      clr_r        <= '0;
      wait_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      wcnt_r       <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (div_start) wait_r <= 1'b1;
      else if (div_done) wait_r <= 1'b0;
      if (state_r == ST_RESP && out_free) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
      if (!IS_POW2 && state_r == ST_ADDR) wcnt_r <= wrap_vld ? 2'd0 : wcnt_r + 2'd1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r   <= in_tdata[1:0];
      haddr_r <= in_tdata[15:2];
      hdata_r <= in_tdata[47:16];
      hlt_r   <= 1'b0;
      flt_r   <= 1'b0;
      rdout_r <= '0;
    end
    if (state_r == ST_ADDR) begin
      wq_r   <= wprod[2*WORD_W-1:WORD_W];
      wrem_r <= wsub[AW:0];
    end
    if (state_r == ST_DATA) begin
      case (step_r)
        SP_HRD: rdout_r <= rd;
        SP_PC0: begin pc_r <= rd; hlt_r <= (rd == '0); end
        SP_OP:  op_r <= rd;
        SP_A, SP_IA: a_r <= rd;
        SP_B, SP_IB: b_r <= rd;
        SP_C, SP_IC: c_r <= rd;
        SP_X:   x_r <= rd;
        SP_Y: begin
          y_r   <= rd;
          n_r   <= n_init;
          i_r   <= '0;
          res_r <= '0;
          if ((opc == OP_DIV || opc == OP_MOD) && rd == '0) flt_r <= 1'b1;
        end
        SP_CR, SP_PC1: tmp_r <= rd;
        default: tmp_r <= tmp_r;
      endcase
    end
    if (state_r == ST_ADDR && wrap_vld && step_r == SP_CW) i_r <= i_r + 1'b1;
    if (state_r == ST_ALU) res_r <= alu_r;
    if (state_r == ST_DIV && div_done) res_r <= (opc == OP_DIV) ? div_q : div_r;
    if (state_r == ST_RESP && out_free) begin
      out_tdata_r <= {6'd0, flt_r && act_r == ACT_EXEC, hlt_r && act_r == ACT_EXEC,
                      (act_r == ACT_READ) ? rdout_r : WORD_W'(0)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  mvs_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ((state_r == ST_CLEAR) ? '0 : wdat),
    .rdata (rd)
  );

  mvs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .sgn       (div_sgn),
    .dividend  (div_a),
    .divisor   (div_b),
    .quotient  (div_q),
    .remainder (div_r),
    .done      (div_done)
  );

  mvs_alu u_alu (
    .opc (opc),
    .x   (x_r),
    .y   (y_r),
    .r   (alu_r)
  );

  `include "assert_macros.svh"
  `MVS_ASSERT(a_clr_block, (state_r == ST_CLEAR) |-> !in_tready, "beat taken during clear")
  `MVS_ASSERT(a_flags_excl, out_tvalid |-> !(out_tdata[32] && out_tdata[33]), "halt and fault")
  `MVS_ASSERT(a_rd_zero, (out_tvalid && |out_tdata[33:32]) |-> !(|out_tdata[31:0]), "flag data")
  `MVS_ASSERT(a_we_state, ram_we |-> (state_r == ST_ADDR || state_r == ST_CLEAR), "stray write")
  `MVS_ASSERT_NXT(a_busy_after, in_tvalid && in_tready, state_r != ST_IDLE, "beat lost")

endmodule

### rtl/core/mvs_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module mvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/core/mvs_div.sv
// Iterative 32-bit divider, one quotient bit per cycle, signed or unsigned.
// Depends on mvs_pkg.
module mvs_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       sgn,
  input  logic [mvs_pkg::WORD_W-1:0] dividend,
  input  logic [mvs_pkg::WORD_W-1:0] divisor,
  output logic [mvs_pkg::WORD_W-1:0] quotient,
  output logic [mvs_pkg::WORD_W-1:0] remainder,
  output logic                       done
);
  import mvs_pkg::*;

  logic                 busy_r, done_r, negq_r, negr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [WORD_W-1:0]    rem_r, quo_r, dvs_r;
  logic [WORD_W:0]      rem_sh, diff;
  logic                 ngx, ngy;

  assign ngx    = sgn & dividend[WORD_W-1];
  assign ngy    = sgn & divisor[WORD_W-1];
  assign rem_sh = {rem_r, quo_r[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring shift-subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= ngx ? -dividend : dividend;
      dvs_r  <= ngy ? -divisor : divisor;
      negq_r <= ngx ^ ngy;
      negr_r <= ngx;
    end else if (busy_r) begin
      if (!diff[WORD_W]) begin
        rem_r <= diff[WORD_W-1:0];
        quo_r <= {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[WORD_W-1:0];
        quo_r <= {quo_r[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = negq_r ? -quo_r : quo_r;
  assign remainder = negr_r ? -rem_r : rem_r;
  assign done      = done_r;

endmodule

### rtl/core/mvs_alu.sv
// Combinational ALU for the non-divide, non-copy opcodes.
// Depends on mvs_pkg.
module mvs_alu (
  input  logic [mvs_pkg::OPC_W-1:0]  opc,
  input  logic [mvs_pkg::WORD_W-1:0] x,
  input  logic [mvs_pkg::WORD_W-1:0] y,
  output logic [mvs_pkg::WORD_W-1:0] r
);
  import mvs_pkg::*;

  logic [4:0] sh;

  assign sh = y[4:0];

  always_comb begin
    case (opc)
      OP_ADD:  r = x + y;
      OP_SUB:  r = x - y;
      OP_MUL:  r = x * y;
      OP_AND:  r = x & y;
      OP_OR:   r = x | y;
      OP_XOR:  r = x ^ y;
      OP_NOT:  r = ~x;
      OP_LNOT: r = WORD_W'(x == '0);
      OP_SHL:  r = x << sh;
      OP_SHR:  r = x >> sh;
      OP_SAR:  r = WORD_W'($signed(x) >>> sh);
      OP_GT:   r = WORD_W'($signed(x) > $signed(y));
      OP_EQ:   r = WORD_W'(x == y);
      default: r = '0;
    endcase
  end

endmodule
